// ----- hdl/olist_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types, field widths and command/status codes of the ordered record
// list.
// ----------------------------------------------------------------------------
package olist_pkg;

   localparam int DEPTH_DEF = 64;

   localparam int CMD_W    = 3;
   localparam int IDX_W    = 7;
   localparam int KEY_W    = 32;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SORTED = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SORT   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic signed [KEY_W-1:0] payload;
   } ol_rec_type;

   typedef struct packed {
      logic [CMD_W-1:0]        command;
      logic [IDX_W-1:0]        index;
      logic signed [KEY_W-1:0] key;
      logic signed [KEY_W-1:0] payload;
   } ol_cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [IDX_W-1:0]        count;
      logic signed [KEY_W-1:0] read_key;
      logic signed [KEY_W-1:0] read_payload;
   } ol_rsp_type;

   function automatic logic key_greater(input logic signed [KEY_W-1:0] a,
                                        input logic signed [KEY_W-1:0] b);
      return a > b;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/olist_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// olist_mem
// Record store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module olist_mem
   import olist_pkg::*;
#(
   parameter int DEPTH  = DEPTH_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire ol_rec_type        wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output ol_rec_type             rd_data_ff
);

   ol_rec_type store_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ----- hdl/olist_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// olist_ctrl
// Command sequencer: walks the record store through its single read and
// write port with one shared key comparator.
// ----------------------------------------------------------------------------
module olist_ctrl
   import olist_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire ol_cmd_type cmd,
   output logic            idle,
   output logic            res_valid,
   input  wire logic       res_take,
   output ol_rsp_type      res
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   typedef enum logic [2:0] {
      S_IDLE, S_SHUP, S_SHDN, S_SCAN, S_SORT, S_READ, S_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [CNT_W-1:0]        ptr_ff, ptr_in;
   logic [CNT_W-1:0]        wa_ff, wa_in;
   logic [CNT_W-1:0]        pos_ff, pos_in;
   logic [CNT_W-1:0]        lim_ff, lim_in;
   logic                    pend_ff, pend_in;
   logic                    swapped_ff, swapped_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic signed [KEY_W-1:0] pay_ff, pay_in;
   ol_rec_type              cur_ff, cur_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic signed [KEY_W-1:0] rkey_ff, rkey_in;
   logic signed [KEY_W-1:0] rpay_ff, rpay_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   ol_rec_type        wr_data;
   logic [ADDR_W-1:0] rd_addr;
   ol_rec_type        rd_data;

   logic [CMP_W-1:0] idx_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic [CNT_W-1:0] ptr_m1;
   logic [CNT_W-1:0] ptr_p1;
   logic             full;

   logic signed [KEY_W-1:0] cmp_a;
   logic                    cmp_gt;

   assign idx_ext = CMP_W'(cmd.index);
   assign cnt_ext = CMP_W'(cnt_ff);
   assign ptr_m1  = ptr_ff - CNT_W'(1);
   assign ptr_p1  = ptr_ff + CNT_W'(1);
   assign full    = (cnt_ff >= CNT_W'(DEPTH));

   // The scan compares the new key and the sort the carried key, both against
   // the record just read.
   assign cmp_a  = (state_ff == S_SORT) ? cur_ff.key : key_ff;
   assign cmp_gt = key_greater(cmp_a, rd_data.key);

   olist_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      ptr_in     = ptr_ff;
      wa_in      = wa_ff;
      pos_in     = pos_ff;
      lim_in     = lim_ff;
      pend_in    = 1'b0;
      swapped_in = swapped_ff;
      key_in     = key_ff;
      pay_in     = pay_ff;
      cur_in     = cur_ff;
      status_in  = status_ff;
      rkey_in    = rkey_ff;
      rpay_in    = rpay_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = cur_ff;
      rd_addr    = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               key_in    = cmd.key;
               pay_in    = cmd.payload;
               status_in = ST_OK;
               rkey_in   = '0;
               rpay_in   = '0;
               state_in  = S_DONE;
               case (cmd.command)
                  CMD_INSERT: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else if (idx_ext > cnt_ext) begin
                        status_in = ST_BAD_INDEX;
                     end else begin
                        pos_in   = idx_ext[CNT_W-1:0];
                        ptr_in   = cnt_ff;
                        state_in = S_SHUP;
                     end
                  end
                  CMD_DELETE: begin
                     if (idx_ext >= cnt_ext) begin
                        status_in = ST_BAD_INDEX;
                     end else begin
                        ptr_in   = idx_ext[CNT_W-1:0] + CNT_W'(1);
                        state_in = S_SHDN;
                     end
                  end
                  CMD_SORTED: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        ptr_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
                  CMD_SORT: begin
                     if (cnt_ff > CNT_W'(1)) begin
                        lim_in     = cnt_ff - CNT_W'(1);
                        ptr_in     = '0;
                        swapped_in = 1'b0;
                        state_in   = S_SORT;
                     end
                  end
                  CMD_READ: begin
                     if (idx_ext >= cnt_ext) begin
                        status_in = ST_BAD_INDEX;
                     end else begin
                        rd_addr  = idx_ext[ADDR_W-1:0];
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         // Shift records at pos and above up by one, from the top down,
         // then drop the new record into the gap.
         S_SHUP: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = wa_ff[ADDR_W-1:0];
               wr_data = rd_data;
            end
            if (ptr_ff > pos_ff) begin
               rd_addr = ptr_m1[ADDR_W-1:0];
               wa_in   = ptr_ff;
               ptr_in  = ptr_m1;
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               wr_en           = 1'b1;
               wr_addr         = pos_ff[ADDR_W-1:0];
               wr_data.key     = key_ff;
               wr_data.payload = pay_ff;
               cnt_in          = cnt_ff + CNT_W'(1);
               state_in        = S_DONE;
            end
         end

         // Move each record above the deleted one down by one.
         S_SHDN: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = wa_ff[ADDR_W-1:0];
               wr_data = rd_data;
            end
            if (ptr_ff < cnt_ff) begin
               rd_addr = ptr_ff[ADDR_W-1:0];
               wa_in   = ptr_m1;
               ptr_in  = ptr_p1;
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = S_DONE;
            end
         end

         // Find the first key that is not below the new key.
         S_SCAN: begin
            if (pend_ff && !cmp_gt) begin
               pos_in   = wa_ff;
               ptr_in   = cnt_ff;
               state_in = S_SHUP;
            end else if (ptr_ff < cnt_ff) begin
               rd_addr = ptr_ff[ADDR_W-1:0];
               wa_in   = ptr_ff;
               ptr_in  = ptr_p1;
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               pos_in   = cnt_ff;
               ptr_in   = cnt_ff;
               state_in = S_SHUP;
            end
         end

         // One bubble pass carries the largest record seen so far in
         // cur_ff and writes back the smaller one of each pair; the
         // carried record lands at the top of the pass.
         S_SORT: begin
            if (pend_ff) begin
               if (wa_ff == '0) begin
                  cur_in = rd_data;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = ADDR_W'(wa_ff - CNT_W'(1));
                  if (cmp_gt) begin
                     wr_data    = rd_data;
                     swapped_in = 1'b1;
                  end else begin
                     wr_data = cur_ff;
                     cur_in  = rd_data;
                  end
               end
            end
            if (ptr_ff <= lim_ff) begin
               rd_addr = ptr_ff[ADDR_W-1:0];
               wa_in   = ptr_ff;
               ptr_in  = ptr_p1;
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = lim_ff[ADDR_W-1:0];
               wr_data = cur_ff;
               if (lim_ff == CNT_W'(1) || !swapped_ff) begin
                  state_in = S_DONE;
               end else begin
                  lim_in     = lim_ff - CNT_W'(1);
                  ptr_in     = '0;
                  swapped_in = 1'b0;
               end
            end
         end

         S_READ: begin
            rkey_in  = rd_data.key;
            rpay_in  = rd_data.payload;
            state_in = S_DONE;
         end

         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
      ptr_ff     <= ptr_in;
      wa_ff      <= wa_in;
      pos_ff     <= pos_in;
      lim_ff     <= lim_in;
      swapped_ff <= swapped_in;
      key_ff     <= key_in;
      pay_ff     <= pay_in;
      cur_ff     <= cur_in;
      status_ff  <= status_in;
      rkey_ff    <= rkey_in;
      rpay_ff    <= rpay_in;
   end

   logic [CMP_W-1:0] cnt_out;
   assign cnt_out = CMP_W'(cnt_ff);

   assign idle             = (state_ff == S_IDLE);
   assign res_valid        = (state_ff == S_DONE);
   assign res.status       = status_ff;
   assign res.count        = cnt_out[IDX_W-1:0];
   assign res.read_key     = rkey_ff;
   assign res.read_payload = rpay_ff;

endmodule
`default_nettype wire

// ----- hdl/ordered_record_list.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_record_list
// List of up to DEPTH signed-key records with indexed insert and delete,
// sorted insert, stable ascending sort and indexed read.
// ----------------------------------------------------------------------------
//  Channel | Direction | Ports        | Contents
//  req     | in        | req_tdata    | command, index, key, payload
//  rsp     | out       | rsp_tdata    | status, count, read_key, read_payload
//
//  Each command walks the list through the store's one read and one write port (n = count,
//  i = index): insert shifts the n-i records at and above the index up; delete shifts the
//  n-i-1 records above it down; sorted insert scans for its place and then shifts; read
//  is one lookup; sort makes up to n-1 bubble passes, each later one a record shorter,
//  stopping after a pass without a swap; rejected or no-op commands leave the list as is.
//  Reset clears only the fill count and control. A stalled result holds req_tready low.
// ----------------------------------------------------------------------------
module ordered_record_list
   import olist_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,  // command, index, key, payload, zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata   // status, count, read_key, read_payload, zero pad
);

   ol_cmd_type cmd;
   ol_rsp_type res;
   ol_rsp_type rsp_data_ff, rsp_data_in;
   logic       rsp_tvalid_ff, rsp_tvalid_in;
   logic       idle;
   logic       res_valid;
   logic       res_take;
   logic       start;

   assign cmd.command = req_tdata[2:0];
   assign cmd.index   = req_tdata[9:3];
   assign cmd.key     = req_tdata[41:10];
   assign cmd.payload = req_tdata[73:42];

   assign req_tready = idle && !reset;
   assign start      = req_tvalid && req_tready;
   assign res_take   = res_valid && (!rsp_tvalid_ff || rsp_tready);

   olist_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmd       (cmd),
      .idle      (idle),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res)
   );

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_data_in   = rsp_data_ff;
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (res_take) begin
         rsp_tvalid_in = 1'b1;
         rsp_data_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff.read_payload, rsp_data_ff.read_key,
                        rsp_data_ff.count, rsp_data_ff.status};

endmodule
`default_nettype wire

// ----- sim/olist_monitor.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// olist_monitor
// Watches both streams of the ordered record list and keeps its own copy of
// the list. Every accepted command is applied to that copy and the answer is
// queued. Every accepted result is compared field by field with the oldest
// queued answer.
// ----------------------------------------------------------------------------
module olist_monitor
   import olist_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [79:0] req_tdata,  // command, index, key, payload, zero pad
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [79:0] rsp_tdata,  // status, count, read_key, read_payload, zero pad
   output int               fail_count,
   output int               pending,
   output int               checked,
   output int               full_replies,
   output int               range_replies,
   output int               peak_fill
);

   logic signed [KEY_W-1:0] key_copy [DEPTH];
   logic signed [KEY_W-1:0] payload_copy [DEPTH];
   int                      fill;
   ol_rsp_type              answers [$];
   int                      mismatches;
   int                      n_checked;
   int                      n_full;
   int                      n_range;
   int                      n_peak;

   initial begin
      fill       = 0;
      mismatches = 0;
      n_checked  = 0;
      n_full     = 0;
      n_range    = 0;
      n_peak     = 0;
   end

   // Opens a slot at pos by moving the records above it up by one.
   function automatic void place_record(input int pos, input logic signed [KEY_W-1:0] k,
                                        input logic signed [KEY_W-1:0] p);
      for (int j = fill; j > pos; j--) begin
         key_copy[j]     = key_copy[j-1];
         payload_copy[j] = payload_copy[j-1];
      end
      key_copy[pos]     = k;
      payload_copy[pos] = p;
      fill++;
   endfunction

   function automatic ol_rsp_type apply_command(input ol_cmd_type c);
      ol_rsp_type              ans;
      int                      pos;
      logic                    found;
      logic signed [KEY_W-1:0] t;
      ans        = '0;
      ans.status = ST_OK;
      case (c.command)
         CMD_INSERT: begin
            if (fill >= DEPTH)
               ans.status = ST_FULL;
            else if (c.index > fill)
               ans.status = ST_BAD_INDEX;
            else
               place_record(c.index, c.key, c.payload);
         end
         CMD_DELETE: begin
            if (c.index >= fill) begin
               ans.status = ST_BAD_INDEX;
            end else begin
               for (int j = c.index + 1; j < fill; j++) begin
                  key_copy[j-1]     = key_copy[j];
                  payload_copy[j-1] = payload_copy[j];
               end
               fill--;
            end
         end
         CMD_SORTED: begin
            if (fill >= DEPTH) begin
               ans.status = ST_FULL;
            end else begin
               // The new record goes ahead of the first key that is not smaller.
               pos   = fill;
               found = 1'b0;
               for (int i = 0; i < fill; i++) begin
                  if (!found && !(c.key > key_copy[i])) begin
                     pos   = i;
                     found = 1'b1;
                  end
               end
               place_record(pos, c.key, c.payload);
            end
         end
         CMD_SORT: begin
            // Swapping only on a strict greater keeps equal keys in order.
            for (int i = 0; i + 1 < fill; i++) begin
               for (int j = 0; j + 1 < fill - i; j++) begin
                  if (key_copy[j] > key_copy[j+1]) begin
                     t                 = key_copy[j];
                     key_copy[j]       = key_copy[j+1];
                     key_copy[j+1]     = t;
                     t                 = payload_copy[j];
                     payload_copy[j]   = payload_copy[j+1];
                     payload_copy[j+1] = t;
                  end
               end
            end
         end
         CMD_READ: begin
            if (c.index >= fill) begin
               ans.status = ST_BAD_INDEX;
            end else begin
               ans.read_key     = key_copy[c.index];
               ans.read_payload = payload_copy[c.index];
            end
         end
         default: ;
      endcase
      ans.count = fill[IDX_W-1:0];
      return ans;
   endfunction

   always @(posedge clock) begin
      ol_cmd_type cmd;
      ol_rsp_type got;
      ol_rsp_type wanted;
      if (reset) begin
         fill = 0;
         answers.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status       = rsp_tdata[1:0];
            got.count        = rsp_tdata[8:2];
            got.read_key     = rsp_tdata[40:9];
            got.read_payload = rsp_tdata[72:41];
            if (answers.size() == 0) begin
               $error("result transfer with no command outstanding");
               mismatches++;
            end else begin
               wanted = answers.pop_front();
               n_checked++;
               if (got.status !== wanted.status) begin
                  $error("status: expected %0d, got %0d", wanted.status, got.status);
                  mismatches++;
               end
               if (got.count !== wanted.count) begin
                  $error("count: expected %0d, got %0d", wanted.count, got.count);
                  mismatches++;
               end
               if (got.read_key !== wanted.read_key) begin
                  $error("read_key: expected %0d, got %0d", wanted.read_key, got.read_key);
                  mismatches++;
               end
               if (got.read_payload !== wanted.read_payload) begin
                  $error("read_payload: expected %0d, got %0d",
                         wanted.read_payload, got.read_payload);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            cmd.command = req_tdata[2:0];
            cmd.index   = req_tdata[9:3];
            cmd.key     = req_tdata[41:10];
            cmd.payload = req_tdata[73:42];
            wanted = apply_command(cmd);
            if (wanted.status == ST_FULL)
               n_full++;
            if (wanted.status == ST_BAD_INDEX)
               n_range++;
            if (fill > n_peak)
               n_peak = fill;
            answers.push_back(wanted);
         end
      end
      // Handed over with nonblocking updates so the stimulus side reads a
      // settled value at every edge.
      fail_count    <= mismatches;
      pending       <= answers.size();
      checked       <= n_checked;
      full_replies  <= n_full;
      range_replies <= n_range;
      peak_fill     <= n_peak;
   end

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the ordered record list. A short directed run
// covers the empty list, single records, extreme keys, equal keys, bad
// indexes and unused command codes; random traffic then alternates between
// filling the list to its limit and draining it, under changing idle patterns
// on both streams. Checking is done by olist_monitor.
// ----------------------------------------------------------------------------
module tb
   import olist_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 400;
   localparam int HOLD_AT_ITEM   = 360;
   localparam int PHASE_ITEMS    = 160;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata  = '0;  // command, index, key, payload, zero pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;        // status, count, read_key, read_payload, zero pad

   int fail_count;
   int pending;
   int checked;
   int full_replies;
   int range_replies;
   int peak_fill;

   int send_idle = 30;
   int recv_idle = 70;
   int n_sent    = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;
   int quiet_cycles = 0;

   always #5 clock = ~clock;

   ordered_record_list #(.DEPTH(DEPTH_DEF)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   olist_monitor #(.DEPTH(DEPTH_DEF)) list_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked       (checked),
      .full_replies  (full_replies),
      .range_replies (range_replies),
      .peak_fill     (peak_fill)
   );

   // Result side: random back-pressure, plus one long hold-off so that the
   // block's results back up and it has to stall its command input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         hold_done  <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!hold_done && n_sent >= HOLD_AT_ITEM) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic send_command(input logic [CMD_W-1:0] command,
                               input logic [IDX_W-1:0] index,
                               input logic [KEY_W-1:0] key,
                               input logic [KEY_W-1:0] payload);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, payload, key, index, command};
      do
         @(posedge clock);
      while (!req_tready);
      n_sent++;
   endtask

   // Lets every outstanding command come back before going on.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   function automatic logic [KEY_W-1:0] random_key();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5)
         return $urandom();
      else if (r < 8)
         return KEY_W'($signed($urandom_range(0, 8)) - 4);  // many equal keys
      else if (r == 8)
         return 32'h7fff_ffff;
      else
         return 32'h8000_0000;
   endfunction

   function automatic logic [IDX_W-1:0] random_index();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4)
         return IDX_W'($urandom_range(0, 3));
      else if (r < 8)
         return IDX_W'($urandom_range(0, DEPTH_DEF));
      else
         return IDX_W'($urandom_range(0, 127));
   endfunction

   // The command mix leans toward growing the list in the first half of each
   // phase and toward shrinking it in the last quarter.
   function automatic logic [CMD_W-1:0] random_command(input int step);
      int r;
      int pos;
      r   = $urandom_range(0, 99);
      pos = step % PHASE_ITEMS;
      if (pos < PHASE_ITEMS / 2) begin
         if (r < 45) return CMD_SORTED;
         if (r < 70) return CMD_INSERT;
         if (r < 80) return CMD_READ;
         if (r < 87) return CMD_DELETE;
         if (r < 92) return CMD_SORT;
      end else if (pos < PHASE_ITEMS * 3 / 4) begin
         if (r < 20) return CMD_SORTED;
         if (r < 40) return CMD_INSERT;
         if (r < 60) return CMD_READ;
         if (r < 75) return CMD_DELETE;
         if (r < 90) return CMD_SORT;
      end else begin
         if (r < 10) return CMD_SORTED;
         if (r < 20) return CMD_INSERT;
         if (r < 45) return CMD_READ;
         if (r < 90) return CMD_DELETE;
         if (r < 95) return CMD_SORT;
      end
      return CMD_W'($urandom_range(5, 7));
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Empty list: nothing to read, delete or sort; only index 0 is open.
      send_command(CMD_READ, 0, 0, 0);
      send_command(CMD_DELETE, 0, 0, 0);
      send_command(CMD_SORT, 0, 0, 0);
      send_command(CMD_INSERT, 1, 32'h1111_1111, 32'h2222_2222);
      // Sorted insert into an empty list, then past every key.
      send_command(CMD_SORTED, 0, 5, 32'h0000_0050);
      send_command(CMD_SORT, 0, 0, 0);
      send_command(CMD_SORTED, 0, 9, 32'h0000_0090);
      send_command(CMD_INSERT, 0, 32'h7fff_ffff, 32'h8000_0000);
      send_command(CMD_INSERT, 3, 32'h8000_0000, 32'h7fff_ffff);
      // Equal keys: the new record lands ahead of the stored one.
      send_command(CMD_SORTED, 0, 5, 32'h0000_0051);
      send_command(CMD_SORTED, 0, 32'h7fff_ffff, 32'hffff_ffff);
      send_command(CMD_SORT, 0, 0, 0);
      send_command(CMD_READ, 0, 0, 0);
      send_command(CMD_READ, 1, 0, 0);
      send_command(CMD_READ, 2, 0, 0);
      send_command(CMD_READ, 5, 0, 0);
      send_command(CMD_READ, 127, 0, 0);
      send_command(CMD_DELETE, 127, 0, 0);
      send_command(CMD_INSERT, 127, 32'hffff_ffff, 32'hffff_ffff);
      send_command(3'd5, 127, 32'hffff_ffff, 32'hffff_ffff);
      send_command(3'd6, 0, 0, 0);
      send_command(3'd7, 64, 32'h8000_0000, 32'h7fff_ffff);
      send_command(CMD_DELETE, 0, 0, 0);
      send_command(CMD_DELETE, 4, 0, 0);
      send_command(CMD_READ, 4, 0, 0);

      for (int phase = 0; phase < 3; phase++) begin
         wait_for_results();
         send_idle = (phase == 0) ? 30 : (phase == 1) ? 70 : 0;
         recv_idle = (phase == 0) ? 70 : (phase == 1) ? 30 : 0;
         for (int n = 0; n < PHASE_ITEMS + 5; n++)
            send_command(random_command(n), random_index(), random_key(), $urandom());
      end

      wait_for_results();
      repeat (50) @(posedge clock);

      $display("Sent %0d commands, checked %0d results; the list peaked at %0d records.",
               n_sent, checked, peak_fill);
      $display("Replies for a full list: %0d, for an index out of range: %0d.",
               full_replies, range_replies);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
`default_nettype wire

// ----- sim.f -----
hdl/olist_pkg.sv
hdl/olist_mem.sv
hdl/olist_ctrl.sv
hdl/ordered_record_list.sv
sim/olist_monitor.sv
sim/tb.sv
